### src/yuvcd_pkg.sv
// Shared types and constants for the YUV chroma down-sampler and packer.
`timescale 1ns / 1ps

package yuvcd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SAMPLE_BITS  = 3'd2;
    localparam logic [2:0] REG_CHROMA_MODE  = 3'd3;
    localparam logic [2:0] REG_SEMI_PLANAR  = 3'd4;
    localparam logic [2:0] REG_HIGH_ALIGNED = 3'd5;

    // Destination planes
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_C = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    // Rescale constants
    localparam logic [31:0] ROUND_BIAS   = 32'd32767;
    localparam logic [16:0] FULL_SCALE   = 17'd65535;
    localparam logic [16:0] FULL_SCALE_2 = 17'd131070;
    localparam logic [4:0]  SAMPLE_MAX   = 5'd16;
    localparam logic [4:0]  SAMPLE_MIN   = 5'd8;

    // Chroma block shape
    typedef enum logic [1:0] {
        MODE_FULL = 2'd0,
        MODE_HALF = 2'd1,
        MODE_QUAD = 2'd2
    } t_mode;

    // Output beat position within one pixel's results
    typedef enum logic [1:0] {
        BEAT_Y = 2'd0,
        BEAT_U = 2'd1,
        BEAT_V = 2'd2
    } t_beat;

    // Per-pixel control decided at input time
    typedef struct packed {
        logic        emit;      // chroma block completes on this pixel
        logic        set_pair;  // even column: load horizontal pair
        logic        wr_line;   // odd flipped row: store pair sum in line store
        t_mode       mode;
        logic [11:0] fr;        // flipped luma row
        logic [11:0] col;       // luma column
        logic [11:0] crow;      // chroma row
        logic [11:0] ccol;      // chroma block column
    } t_pix_ctl;

    // Everything the output queue needs for one pixel
    typedef struct packed {
        logic        emit;
        logic [15:0] y;
        logic [15:0] u;
        logic [15:0] v;
        logic [11:0] fr;
        logic [11:0] col;
        logic [11:0] crow;
        logic [11:0] ccol;
    } t_res;

endpackage

### src/yuvcd_scale_stage.sv
// Pipeline stage that rescales raw 16-bit channels to the configured sample depth.
`timescale 1ns / 1ps

module yuvcd_scale_stage
    import yuvcd_pkg::*;
#(
    parameter int AW = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0][15:0]     i_raw,
    input  logic [4:0]           i_bits,
    input  t_pix_ctl             i_ctl,
    input  logic [AW-1:0]        i_cx,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0][15:0]     o_val,
    output t_pix_ctl             o_ctl,
    output logic [AW-1:0]        o_cx
);

    logic              r_valid;
    logic [2:0][31:0]  r_x;
    t_pix_ctl          r_ctl;
    logic [AW-1:0]     r_cx;
    logic [2:0][31:0]  n_x;

    assign o_ready = !r_valid || i_ready;

    // Numerator v*(2^bits-1)+32767. At 8 bits the raw byte is placed at
    // bit 16 so the quotient below returns it unchanged.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_bits <= SAMPLE_MIN) begin
                n_x[k] = {8'h00, i_raw[k][7:0], 16'h0000};
            end else begin
                n_x[k] = ({16'h0000, i_raw[k]} << i_bits) - {16'h0000, i_raw[k]} + ROUND_BIAS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x   <= n_x;
            r_ctl <= i_ctl;
            r_cx  <= i_cx;
        end
    end

    // Divide by 65535: q0 = x>>16, remainder q0 + low half, at most two corrections
    always_comb begin
        logic [16:0] rem;
        for (int k = 0; k < 3; k++) begin
            rem = {1'b0, r_x[k][15:0]} + {1'b0, r_x[k][31:16]};
            o_val[k] = r_x[k][31:16] + {15'd0, (rem >= FULL_SCALE)}
                                     + {15'd0, (rem >= FULL_SCALE_2)};
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_cx    = r_cx;

endmodule

### src/yuvcd_chroma_stage.sv
// Chroma box averaging stage with the line store of partial block sums.
`timescale 1ns / 1ps

module yuvcd_chroma_stage
    import yuvcd_pkg::*;
#(
    parameter int AW = 11,
    parameter int LD = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0][15:0] i_val,
    input  t_pix_ctl         i_ctl,
    input  logic [AW-1:0]    i_cx,
    input  logic [4:0]       i_bits,
    input  logic             i_high,
    output logic             o_valid,
    input  logic             i_ready,
    output t_res             o_res
);

    // Line store: {cr sum, cb sum} of the odd flipped row, per block column
    logic [33:0]      mem [LD];
    logic [33:0]      r_line;

    logic             r_valid;
    logic [2:0][15:0] r_val;
    t_pix_ctl         r_ctl;
    logic [AW-1:0]    r_cx;
    logic [15:0]      r_pair_u;
    logic [15:0]      r_pair_v;

    logic [16:0]      su;
    logic [16:0]      sv;
    logic [17:0]      bu;
    logic [17:0]      bv;
    logic [15:0]      avg_u;
    logic [15:0]      avg_v;
    logic [4:0]       shamt;
    logic             fire_in;
    logic             fire_out;

    assign fire_out = r_valid && i_ready;
    assign o_ready  = !r_valid || i_ready;
    assign fire_in  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Take the pixel and read its line-store entry on the same edge
    always_ff @(posedge i_clk) begin
        if (fire_in) begin
            r_val  <= i_val;
            r_ctl  <= i_ctl;
            r_cx   <= i_cx;
            r_line <= mem[i_cx];
        end
    end

    // Write back when the pixel leaves; a reader that uses the same entry is always
    // at least two pixels behind, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (fire_out && r_ctl.wr_line) begin
            mem[r_cx] <= {sv, su};
        end
    end

    // Horizontal pair registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_u <= '0;
            r_pair_v <= '0;
        end else if (fire_out && r_ctl.set_pair) begin
            r_pair_u <= r_val[1];
            r_pair_v <= r_val[2];
        end
    end

    // Sums and rounded averages
    always_comb begin
        su = {1'b0, r_pair_u} + {1'b0, r_val[1]};
        sv = {1'b0, r_pair_v} + {1'b0, r_val[2]};
        bu = {1'b0, r_line[16:0]}  + {1'b0, su} + 18'd2;
        bv = {1'b0, r_line[33:17]} + {1'b0, sv} + 18'd2;
        case (r_ctl.mode)
            MODE_FULL: begin
                avg_u = r_val[1];
                avg_v = r_val[2];
            end
            MODE_HALF: begin
                avg_u = 16'((su + 17'd1) >> 1);
                avg_v = 16'((sv + 17'd1) >> 1);
            end
            default: begin
                avg_u = bu[17:2];
                avg_v = bv[17:2];
            end
        endcase
    end

    // High alignment
    assign shamt = i_high ? (SAMPLE_MAX - i_bits) : 5'd0;

    always_comb begin
        o_res.emit = r_ctl.emit;
        o_res.y    = r_val[0] << shamt;
        o_res.u    = avg_u << shamt;
        o_res.v    = avg_v << shamt;
        o_res.fr   = r_ctl.fr;
        o_res.col  = r_ctl.col;
        o_res.crow = r_ctl.crow;
        o_res.ccol = r_ctl.ccol;
    end

    assign o_valid = r_valid;

endmodule

### src/yuvcd_out_queue.sv
// Output register that serializes each pixel's luma and chroma beats.
`timescale 1ns / 1ps

module yuvcd_out_queue
    import yuvcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_res        i_res,
    input  logic        i_semi,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    logic        r_valid;
    t_res        r_res;
    t_beat       r_beat;
    logic        last;
    logic [11:0] row;
    logic [11:0] col;
    logic [15:0] val;
    logic [1:0]  plane;

    assign last    = (r_beat == BEAT_V) || (r_beat == BEAT_Y && !r_res.emit);
    assign o_ready = !r_valid || (i_m_axis_tready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= BEAT_Y;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_beat  <= BEAT_Y;
        end else if (i_m_axis_tready) begin
            r_beat  <= (r_beat == BEAT_Y) ? BEAT_U : BEAT_V;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    // Beat select
    always_comb begin
        case (r_beat)
            BEAT_Y: begin
                plane = PLANE_Y;
                row   = r_res.fr;
                col   = r_res.col;
                val   = r_res.y;
            end
            BEAT_U: begin
                plane = PLANE_C;
                row   = r_res.crow;
                col   = i_semi ? {r_res.ccol[10:0], 1'b0} : r_res.ccol;
                val   = r_res.u;
            end
            default: begin
                plane = i_semi ? PLANE_C : PLANE_V;
                row   = r_res.crow;
                col   = i_semi ? {r_res.ccol[10:0], 1'b1} : r_res.ccol;
                val   = r_res.v;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {val, col, row};
    assign o_m_axis_tuser  = plane;
    assign o_m_axis_tlast  = last;

endmodule

### src/yuv_chroma_downsample_packer_unit.sv
// Top level of the YUV chroma down-sampler and packer.
// An accepted input beat passes the scale, chroma and output queue registers
// before its luma output beat. Throughput: one output beat per cycle while
// the output is ready; a pixel gives one beat (luma only) or three beats
// (luma, U, V). 4:2:0 averages 1.5 beats per pixel, 4:2:2 two, 4:4:4 three.
// Reset (synchronous, active low) clears counters, pair registers, pipeline valids
// and restores config defaults; the line store is not cleared.
`timescale 1ns / 1ps

module yuv_chroma_downsample_packer_unit
    import yuvcd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    // input pixels
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // luma_raw, cb_raw, cr_raw
    // output samples
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // out_row, out_col, value
    output logic [1:0]  o_m_axis_tuser,  // plane
    output logic        o_m_axis_tlast
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = CW + 1;
    localparam int HW = RW + 1;
    localparam int AW = (CW > 1) ? CW - 1 : 1;
    localparam int LD = MAX_WIDTH / 2;

    // Configuration registers
    logic [12:0] r_cfg_w;
    logic [12:0] r_cfg_h;
    logic [4:0]  r_cfg_bits;
    logic [1:0]  r_cfg_mode;
    logic        r_cfg_semi;
    logic        r_cfg_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= 13'd1920;
            r_cfg_h    <= 13'd1080;
            r_cfg_bits <= 5'd8;
            r_cfg_mode <= MODE_QUAD;
            r_cfg_semi <= 1'b0;
            r_cfg_high <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_cfg_w    <= i_cfg_data;
                REG_FRAME_HEIGHT: r_cfg_h    <= i_cfg_data;
                REG_SAMPLE_BITS:  r_cfg_bits <= i_cfg_data[4:0];
                REG_CHROMA_MODE:  r_cfg_mode <= i_cfg_data[1:0];
                REG_SEMI_PLANAR:  r_cfg_semi <= i_cfg_data[0];
                REG_HIGH_ALIGNED: r_cfg_high <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective settings
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [4:0]    bits_eff;
    t_mode         mode_eff;

    always_comb begin
        if (r_cfg_w == 13'd0)            w_eff = WW'(1);
        else if (32'(r_cfg_w) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
        else                             w_eff = WW'(r_cfg_w);
        if (r_cfg_h == 13'd0)             h_eff = HW'(1);
        else if (32'(r_cfg_h) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
        else                              h_eff = HW'(r_cfg_h);
        if (r_cfg_bits < SAMPLE_MIN)      bits_eff = SAMPLE_MIN;
        else if (r_cfg_bits > SAMPLE_MAX) bits_eff = SAMPLE_MAX;
        else                              bits_eff = r_cfg_bits;
        case (r_cfg_mode)
            MODE_FULL: mode_eff = MODE_FULL;
            MODE_HALF: mode_eff = MODE_HALF;
            default:   mode_eff = MODE_QUAD;
        endcase
    end

    // Raster counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic          in_fire;

    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign col_cur = (WW'(r_col) >= w_eff) ? '0 : r_col;
    assign row_cur = (HW'(r_row) >= h_eff) ? '0 : r_row;
    assign col_inc = WW'(col_cur) + WW'(1);
    assign row_inc = HW'(row_cur) + HW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (col_inc >= w_eff) begin
                r_col <= '0;
                r_row <= (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
            end else begin
                r_col <= col_inc[CW-1:0];
                r_row <= row_cur;
            end
        end
    end

    // Per-pixel block decisions
    logic [HW-1:0] fr;
    logic [31:0]   fr32;
    logic [31:0]   col32;
    logic          odd_col;
    logic          odd_fr;
    t_pix_ctl      ctl0;
    logic [AW-1:0] cx0;

    assign fr    = h_eff - HW'(1) - HW'(row_cur);
    assign fr32  = 32'(fr);
    assign col32 = 32'(col_cur);
    assign odd_col = col32[0];
    assign odd_fr  = fr32[0];
    assign cx0     = col32[AW:1];

    always_comb begin
        ctl0.mode     = mode_eff;
        ctl0.set_pair = (mode_eff != MODE_FULL) && !odd_col;
        ctl0.wr_line  = (mode_eff == MODE_QUAD) && odd_col && odd_fr;
        ctl0.emit     = (mode_eff == MODE_FULL)
                     || (odd_col && (mode_eff == MODE_HALF))
                     || (odd_col && !odd_fr && (row_cur != '0));
        ctl0.fr       = fr32[11:0];
        ctl0.col      = col32[11:0];
        ctl0.crow     = (mode_eff == MODE_QUAD) ? fr32[12:1] : fr32[11:0];
        ctl0.ccol     = (mode_eff == MODE_FULL) ? col32[11:0] : col32[12:1];
    end

    // Pipeline
    logic             s1_valid;
    logic             s1_ready;
    logic [2:0][15:0] s1_val;
    t_pix_ctl         s1_ctl;
    logic [AW-1:0]    s1_cx;
    logic             s2_valid;
    logic             s2_ready;
    t_res             s2_res;
    logic [2:0][15:0] raw;

    assign raw[0] = i_s_axis_tdata[15:0];
    assign raw[1] = i_s_axis_tdata[31:16];
    assign raw[2] = i_s_axis_tdata[47:32];

    yuvcd_scale_stage #(
        .AW (AW)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_raw   (raw),
        .i_bits  (bits_eff),
        .i_ctl   (ctl0),
        .i_cx    (cx0),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_val   (s1_val),
        .o_ctl   (s1_ctl),
        .o_cx    (s1_cx)
    );

    yuvcd_chroma_stage #(
        .AW (AW),
        .LD (LD)
    ) u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_val   (s1_val),
        .i_ctl   (s1_ctl),
        .i_cx    (s1_cx),
        .i_bits  (bits_eff),
        .i_high  (r_cfg_high),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_res   (s2_res)
    );

    yuvcd_out_queue u_outq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s2_valid),
        .o_ready         (s2_ready),
        .i_res           (s2_res),
        .i_semi          (r_cfg_semi),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Checks
    logic out_fire;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;

    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> s1_valid)
        else $error("accepted pixel not held in scale stage");

    a_chroma_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !o_m_axis_tlast) |=> (o_m_axis_tvalid && o_m_axis_tuser != PLANE_Y))
        else $error("pixel results cut short before its last beat");

    a_v_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == PLANE_V) |-> o_m_axis_tlast)
        else $error("V plane beat not marked last");

endmodule
